// ===== rtl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

  // coordinate width and the widths that follow from it
  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int SPAN_BITS  = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                       opcode;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic                          last;
  } out_word_t;

  // classified command, line setup already worked out for a start
  typedef struct packed {
    opcode_e                       opcode;
    logic                          x_is_major;
    logic                          minor_dir;
    logic                          active;
    logic signed [COORD_BITS-1:0]  cur_x;
    logic signed [COORD_BITS-1:0]  cur_y;
    logic signed [COORD_BITS-1:0]  major_end;
    logic [SPAN_BITS-1:0]          twice_minor;
    logic signed [DEC_BITS-1:0]    dec_down;
    logic signed [DEC_BITS-1:0]    decision;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lps_front.sv =====
`default_nettype none

module lps_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire lps_pkg::in_word_t in_word_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output lps_pkg::cmd_t         cmd_o
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int DW = lps_pkg::DELTA_BITS;
  localparam int EW = lps_pkg::DEC_BITS;

  logic                   v_q;
  lps_pkg::in_word_t      item_q;
  logic signed [DW-1:0]   dx_q, dy_q;
  logic signed [DW-1:0]   dx_d, dy_d;

  logic                   adv;

  logic [DW-1:0]          adx, ady;
  logic                   x_major, swap;
  logic signed [DW-1:0]   ndx, ndy, dmaj, dmin, dmin_neg;
  logic                   minor_dir;
  logic [DW-1:0]          dmin_mag;
  logic signed [C-1:0]    sx, sy, ex, ey, major_end, start_major;
  logic signed [EW-1:0]   two_min, dmaj_ext, two_maj;

  assign adv         = !v_q || cmd_ready_i;
  assign full        = !adv;
  assign cmd_valid_o = v_q;

  assign dx_d = {in_word_i.x_end[C-1], in_word_i.x_end}
              - {in_word_i.x_start[C-1], in_word_i.x_start};
  assign dy_d = {in_word_i.y_end[C-1], in_word_i.y_end}
              - {in_word_i.y_start[C-1], in_word_i.y_start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      item_q <= in_word_i;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
    end
  end

  // classify octant and order the endpoints along the major axis
  always_comb begin
    adx     = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    ady     = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    x_major = ady < adx;
    swap    = x_major ? (dx_q <= 0) : (dy_q <= 0);

    sx = swap ? item_q.x_end   : item_q.x_start;
    sy = swap ? item_q.y_end   : item_q.y_start;
    ex = swap ? item_q.x_start : item_q.x_end;
    ey = swap ? item_q.y_start : item_q.y_end;

    ndx  = swap ? -dx_q : dx_q;
    ndy  = swap ? -dy_q : dy_q;
    dmaj = x_major ? ndx : ndy;
    dmin = x_major ? ndy : ndx;

    minor_dir = dmin[DW-1];
    dmin_neg  = -dmin;
    dmin_mag  = minor_dir ? DW'(dmin_neg) : DW'(dmin);

    major_end   = x_major ? ex : ey;
    start_major = x_major ? sx : sy;

    two_min  = {{(EW-DW-1){1'b0}}, dmin_mag, 1'b0};
    dmaj_ext = {{(EW-DW){dmaj[DW-1]}}, dmaj};
    two_maj  = {{(EW-DW-1){dmaj[DW-1]}}, dmaj, 1'b0};

    cmd_o.opcode      = item_q.opcode;
    cmd_o.x_is_major  = x_major;
    cmd_o.minor_dir   = minor_dir;
    cmd_o.active      = start_major < major_end;
    cmd_o.cur_x       = sx;
    cmd_o.cur_y       = sy;
    cmd_o.major_end   = major_end;
    cmd_o.twice_minor = {dmin_mag, 1'b0};
    cmd_o.dec_down    = two_min - two_maj;
    cmd_o.decision    = two_min - dmaj_ext;
  end

endmodule

`default_nettype wire

// ===== rtl/lps_queue.sv =====
`default_nettype none

module lps_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire lps_pkg::cmd_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output lps_pkg::cmd_t      rd_data_o
);

  localparam int D  = lps_pkg::QUEUE_DEPTH;
  localparam int PW = lps_pkg::QPTR_BITS;

  lps_pkg::cmd_t mem_q [D];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          do_wr, do_rd;

  assign wr_ready_o = count_q != (PW+1)'(D);
  assign rd_valid_o = count_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lps_back.sv =====
`default_nettype none

module lps_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire lps_pkg::cmd_t cmd_i,
  output logic               empty,
  input  wire logic          pop,
  output lps_pkg::out_word_t out_word_o
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int SW = lps_pkg::SPAN_BITS;
  localparam int EW = lps_pkg::DEC_BITS;

  logic                  active_q;
  logic                  x_major_q, minor_dir_q;
  logic signed [C-1:0]   cur_x_q, cur_y_q, major_end_q;
  logic [SW-1:0]         twice_minor_q;
  logic signed [EW-1:0]  dec_down_q, decision_q;

  logic                  out_v_q;
  lps_pkg::out_word_t    out_q;

  logic                  out_free, take, is_start, do_pixel;
  logic signed [C-1:0]   maj, minr, minr_nxt;
  logic signed [C:0]     maj_inc;
  logic                  last;
  logic signed [EW-1:0]  dec_nxt;

  assign is_start    = cmd_i.opcode == lps_pkg::OP_START;
  assign out_free    = !out_v_q || pop;
  assign cmd_ready_o = is_start || !active_q || out_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign do_pixel    = take && !is_start && active_q;

  assign empty      = !out_v_q;
  assign out_word_o = out_q;

  // one step: emit the current pixel, advance major, maybe minor
  always_comb begin
    maj      = x_major_q ? cur_x_q : cur_y_q;
    minr     = x_major_q ? cur_y_q : cur_x_q;
    maj_inc  = {maj[C-1], maj} + 1'b1;
    last     = maj_inc >= $signed({major_end_q[C-1], major_end_q});
    minr_nxt = minr;
    dec_nxt  = decision_q + {{(EW-SW){1'b0}}, twice_minor_q};
    if (decision_q > 0) begin
      minr_nxt = minor_dir_q ? minr - 1'b1 : minr + 1'b1;
      dec_nxt  = decision_q + dec_down_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (take && is_start) begin
        active_q <= cmd_i.active;
      end else if (do_pixel) begin
        active_q <= !last;
      end
      if (do_pixel) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_start) begin
      x_major_q     <= cmd_i.x_is_major;
      minor_dir_q   <= cmd_i.minor_dir;
      cur_x_q       <= cmd_i.cur_x;
      cur_y_q       <= cmd_i.cur_y;
      major_end_q   <= cmd_i.major_end;
      twice_minor_q <= cmd_i.twice_minor;
      dec_down_q    <= cmd_i.dec_down;
      decision_q    <= cmd_i.decision;
    end else if (do_pixel) begin
      decision_q <= dec_nxt;
      if (x_major_q) begin
        cur_x_q <= maj_inc[C-1:0];
        cur_y_q <= minr_nxt;
      end else begin
        cur_y_q <= maj_inc[C-1:0];
        cur_x_q <= minr_nxt;
      end
    end
    if (do_pixel) begin
      out_q.pixel_x <= cur_x_q;
      out_q.pixel_y <= cur_y_q;
      out_q.last    <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/line_pixel_stepper.sv =====
`default_nettype none

// channel   direction  handshake                  word
// ------    ---------  -------------------------  -------------------------------
// input     in         push / full                in_word_i  (opcode + endpoints)
// result    out        empty / pop                out_word_o (pixel x, y, last)
//
// one word per clock in steady state on both sides while pop is held high; a start word
// is always taken by the back end and gives no result, a step word on an active line gives one pixel
// empty falls once a step word has passed the front register, then a command
// queue entry, and the back end output register has loaded the pixel
// reset (rst_ni low) drops the line in progress and empties every stage
// a stalled result (pop low) backs up into the queue, then the front raises full

module line_pixel_stepper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input side
  input  wire logic               push,
  output logic                    full,
  input  wire lps_pkg::in_word_t  in_word_i,
  // result side
  output logic                    empty,
  input  wire logic               pop,
  output lps_pkg::out_word_t      out_word_o
);

  // front to queue
  logic          f_valid, f_ready;
  lps_pkg::cmd_t f_cmd;

  // queue to back
  logic          b_valid, b_ready;
  lps_pkg::cmd_t b_cmd;

  // front: registers the word, works out octant, swap, spans and the
  // initial decision term so the back end only has to load them
  lps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // short queue so a stalled output does not stop the front at once
  lps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  // back: holds the line state, one step per cycle into the output register while it is free or popped
  lps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== tb/line_pixel_checker.sv =====
`timescale 1ns / 1ps

module line_pixel_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               full_i,
  input  wire lps_pkg::in_word_t  in_word_i,
  input  wire logic               empty_i,
  input  wire logic               pop_i,
  input  wire lps_pkg::out_word_t out_word_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      pixels_o,
  output int                      lines_o
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int DW = lps_pkg::DELTA_BITS;
  localparam int SW = lps_pkg::SPAN_BITS;
  localparam int EW = lps_pkg::DEC_BITS;

  // line state as the rasterizer should hold it
  logic signed [C-1:0]  ln_cur_x;
  logic signed [C-1:0]  ln_cur_y;
  logic signed [C-1:0]  ln_major_end;
  logic signed [EW-1:0] ln_decision;
  logic [SW-1:0]        ln_twice_major;
  logic [SW-1:0]        ln_twice_minor;
  logic                 ln_minor_down;
  logic                 ln_x_major;
  logic                 ln_active;

  lps_pkg::out_word_t expected_pixels[$];

  function automatic logic [DW-1:0] span_mag(logic signed [DW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic rasterize_word(input lps_pkg::in_word_t w);
    logic signed [C-1:0]  ax, ay, bx, by, tmp;
    logic signed [DW-1:0] dx, dy, dmaj, dmin, maj, mnr;
    lps_pkg::out_word_t   px;
    if (w.opcode == lps_pkg::OP_START) begin
      ax = w.x_start;
      ay = w.y_start;
      bx = w.x_end;
      by = w.y_end;
      dx = DW'(bx) - DW'(ax);
      dy = DW'(by) - DW'(ay);
      ln_x_major = span_mag(dy) < span_mag(dx);
      // order endpoints so the major coordinate climbs
      if (ln_x_major ? (dx <= 0) : (dy <= 0)) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
        dx = -dx;
        dy = -dy;
      end
      ln_cur_x = ax;
      ln_cur_y = ay;
      if (ln_x_major) begin
        dmaj = dx;
        dmin = dy;
        ln_major_end = bx;
      end else begin
        dmaj = dy;
        dmin = dx;
        ln_major_end = by;
      end
      ln_minor_down = dmin < 0;
      if (dmin < 0) dmin = -dmin;
      ln_twice_major = SW'(2 * dmaj);
      ln_twice_minor = SW'(2 * dmin);
      ln_decision = EW'(2 * dmin - dmaj);
      ln_active = (ln_x_major ? ln_cur_x : ln_cur_y) < ln_major_end;
      lines_o++;
    end else if (ln_active) begin
      maj = DW'(ln_x_major ? ln_cur_x : ln_cur_y);
      mnr = DW'(ln_x_major ? ln_cur_y : ln_cur_x);
      px.pixel_x = ln_cur_x;
      px.pixel_y = ln_cur_y;
      px.last = (maj + 1 >= ln_major_end);
      if (ln_decision > 0) begin
        mnr = ln_minor_down ? DW'(mnr - 1) : DW'(mnr + 1);
        ln_decision = ln_decision - $signed({2'b00, ln_twice_major});
      end
      ln_decision = ln_decision + $signed({2'b00, ln_twice_minor});
      maj = DW'(maj + 1);
      if (maj >= ln_major_end) ln_active = 1'b0;
      if (ln_x_major) begin
        ln_cur_x = maj[C-1:0];
        ln_cur_y = mnr[C-1:0];
      end else begin
        ln_cur_y = maj[C-1:0];
        ln_cur_x = mnr[C-1:0];
      end
      expected_pixels.push_back(px);
    end
  endtask

  task automatic check_pixel(input lps_pkg::out_word_t got);
    lps_pkg::out_word_t want;
    pixels_o++;
    if (expected_pixels.size() == 0) begin
      if (fail_count_o < 10)
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                 got.pixel_x, got.pixel_y, got.last);
      fail_count_o++;
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.last !== want.last) begin
        if (fail_count_o < 10)
          $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                   $realtime, want.pixel_x, want.pixel_y, want.last,
                   got.pixel_x, got.pixel_y, got.last);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_cur_x       = '0;
      ln_cur_y       = '0;
      ln_major_end   = '0;
      ln_decision    = '0;
      ln_twice_major = '0;
      ln_twice_minor = '0;
      ln_minor_down  = 1'b0;
      ln_x_major     = 1'b0;
      ln_active      = 1'b0;
      expected_pixels.delete();
      fail_count_o   = 0;
      pixels_o       = 0;
      lines_o        = 0;
      pending_o      = 0;
    end else begin
      if (pop_i && !empty_i) check_pixel(out_word_i);
      if (push_i && !full_i) rasterize_word(in_word_i);
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_line_pixel_stepper.sv =====
`timescale 1ns / 1ps

module tb_line_pixel_stepper;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // items per idle/stall phase, four phases
  localparam int PHASE_ITEMS = 300;
  // idle pause after every owed pixel has come out
  localparam int DRAIN_CYCLES = 16;
  localparam int C = lps_pkg::COORD_BITS;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  lps_pkg::in_word_t  in_word = '0;
  logic               empty;
  logic               pop = 1'b0;
  lps_pkg::out_word_t out_word;

  int fail_count;
  int pending;
  int pixels;
  int lines;

  // percent of cycles each side sits idle, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // words that can actually move the line (ignored steps left out)
  int live_items = 0;
  int cycle_count = 0;

  line_pixel_stepper uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  line_pixel_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .in_word_i    (in_word),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pixels_o     (pixels),
    .lines_o      (lines)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: pop decided fresh every cycle
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [C-1:0] rand_coord();
    int v = int'($urandom_range(4095)) - 2048;
    return v[C-1:0];
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  // one word onto the input queue; idle gaps come first, then hold until taken
  task automatic push_word(input lps_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic start_line(input int x0, input int y0, input int x1, input int y1);
    lps_pkg::in_word_t w;
    w.opcode = lps_pkg::OP_START;
    w.x_start = x0[C-1:0];
    w.y_start = y0[C-1:0];
    w.x_end = x1[C-1:0];
    w.y_end = y1[C-1:0];
    push_word(w);
  endtask

  // step words carry junk endpoints, the block must ignore them
  task automatic step_line(input int n);
    lps_pkg::in_word_t w;
    repeat (n) begin
      w.opcode = lps_pkg::OP_STEP;
      w.x_start = rand_coord();
      w.y_start = rand_coord();
      w.x_end = rand_coord();
      w.y_end = rand_coord();
      push_word(w);
    end
  endtask

  // a start plus a run of steps; mostly walks the line to its end and a bit past,
  // sometimes cuts it short so the next start replaces it
  task automatic random_line();
    int x0, y0, x1, y1, reach, len, n, pick;
    pick = $urandom_range(99);
    x0 = int'($urandom_range(4095)) - 2048;
    y0 = int'($urandom_range(4095)) - 2048;
    if (pick < 12) begin
      // endpoints anywhere, only a few pixels drawn
      x1 = int'($urandom_range(4095)) - 2048;
      y1 = int'($urandom_range(4095)) - 2048;
    end else begin
      reach = (pick < 20) ? 200 : 24;
      x1 = clamp_coord(x0 + int'($urandom_range(2 * reach)) - reach);
      y1 = clamp_coord(y0 + int'($urandom_range(2 * reach)) - reach);
    end
    len = (abs_int(x1 - x0) > abs_int(y1 - y0)) ? abs_int(x1 - x0) : abs_int(y1 - y0);
    pick = $urandom_range(99);
    if (len > 400) n = $urandom_range(8);
    else if (pick < 70) n = len + $urandom_range(2);
    else if (pick < 90) n = $urandom_range(len);
    else n = $urandom_range(3);
    start_line(x0, y0, x1, y1);
    step_line(n);
    live_items += 1 + ((n < len) ? n : len);
  endtask

  // stop sending until every pixel owed has come out
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines, no idling
    step_line(1);                          // step with nothing loaded
    start_line(5, 5, 5, 5);                // zero-length line
    step_line(1);
    start_line(-2048, -2048, 2047, 2047);  // full-range diagonal, tie goes to y
    step_line(2);
    start_line(2047, 0, -2048, 1);         // x major, endpoints reversed, replaces
    step_line(2);
    start_line(0, 0, 5, 2);                // shallow x major, walked past the end
    step_line(6);
    start_line(3, -1, 1, 3);               // y major with minor going down
    step_line(5);
    start_line(-3, 7, 1, 7);               // horizontal
    step_line(1);
    start_line(2, 2, 2, -1);               // vertical, drawn bottom up
    step_line(4);
    drain();

    // random lines under four idle/stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      target = live_items + PHASE_ITEMS;
      while (live_items < target) random_line();
      drain();
    end

    // final flush with pop held high
    recv_stall_pct = 0;
    drain();

    $display("covered %0d lines and %0d checked pixels over four idle/stall mixes",
             lines, pixels);
    $display("%0d mismatches, %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
